[hw/rtl/kpc_pkg.sv]
// Shared constants, types and byte-classification functions for the keyed
// Polybius cipher block. No dependencies; used by kpc_placer, the top level and kpc_checker.
package kpc_pkg;

  localparam int SIDE     = 5;
  localparam int CELLS    = SIDE * SIDE;
  localparam int LETTERS  = 26;
  localparam int IDX_W    = 5;
  localparam int POS_W    = 5;
  localparam int LETTER_I = 8;
  localparam int LETTER_J = 9;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_KEY    = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_ENC    = 3'd3;
  localparam logic [2:0] OP_DEC    = 3'd4;

  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_LETTER = 1'b1;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } lidx_t;

  typedef struct packed {
    logic             clear;
    logic             place;
    logic [IDX_W-1:0] idx;
  } place_req_t;

  typedef struct packed {
    logic [LETTERS-1:0] mask;
    logic [POS_W-1:0]   fill;
  } place_stat_t;

  // Upper-case a-z, fold J onto I; ok is low for anything not a letter.
  function automatic lidx_t letter_index(input logic [7:0] b);
    logic [7:0] u;
    lidx_t      r;
    u = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
    r.ok  = (u >= 8'h41 && u <= 8'h5a);
    r.idx = IDX_W'(u - 8'h41);
    if (r.idx == IDX_W'(LETTER_J)) begin
      r.idx = IDX_W'(LETTER_I);
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Digit value 1..SIDE, or zero for any other byte.
  function automatic logic [2:0] digit_of(input logic [7:0] b);
    logic [2:0] d;
    d = 3'd0;
    if (b >= 8'h31 && b <= 8'(8'h30 + SIDE)) begin
      d = 3'(b - 8'h30);
    end
    return d;
  endfunction

  // Row 1..SIDE of a square position.
  function automatic logic [2:0] pos_row(input logic [POS_W-1:0] p);
    logic [2:0] r;
    r = 3'd1;
    for (int k = 1; k < SIDE; k++) begin
      if (p >= POS_W'(k * SIDE)) r = 3'(k + 1);
    end
    return r;
  endfunction

  // Column 1..SIDE of a square position.
  function automatic logic [2:0] pos_col(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] base;
    base = '0;
    for (int k = 1; k < SIDE; k++) begin
      if (p >= POS_W'(k * SIDE)) base = POS_W'(k * SIDE);
    end
    return 3'(p - base + POS_W'(1));
  endfunction

  // Cell index of a 1-based row and column pair.
  function automatic logic [POS_W-1:0] cell_of(input logic [2:0] f, input logic [2:0] s);
    logic [POS_W-1:0] fr;
    logic [POS_W-1:0] sc;
    fr = POS_W'(f) - POS_W'(1);
    sc = POS_W'(s) - POS_W'(1);
    return POS_W'(fr * POS_W'(SIDE)) + sc;
  endfunction

endpackage

[hw/rtl/kpc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/kpc_placer.sv]
// Shared letter-placement unit: tracks which letters are in the square and
// how full it is, and issues the write for each newly placed letter. Uses kpc_pkg.
module kpc_placer (
  input  logic                clk,
  input  logic                rst,
  input  kpc_pkg::place_req_t req,
  output logic                we,
  output kpc_pkg::place_stat_t stat
);

  logic [kpc_pkg::LETTERS-1:0] placed_mask;
  logic [kpc_pkg::POS_W-1:0]   fill_count;

  // Accept only a fresh, real letter while the square has room.
  assign we = req.place && !req.clear
            && (req.idx < kpc_pkg::IDX_W'(kpc_pkg::LETTERS))
            && (req.idx != kpc_pkg::IDX_W'(kpc_pkg::LETTER_J))
            && !placed_mask[req.idx]
            && (fill_count < kpc_pkg::POS_W'(kpc_pkg::CELLS));

  assign stat.mask = placed_mask;
  assign stat.fill = fill_count;

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      placed_mask <= '0;
      fill_count  <= '0;
    end else if (we) begin
      placed_mask[req.idx] <= 1'b1;
      fill_count           <= fill_count + kpc_pkg::POS_W'(1);
    end
  end

endmodule

[hw/rtl/keyed_polybius_cipher.sv]
// Keyed 5x5 Polybius cipher, top level. Uses kpc_pkg, kpc_placer, kpc_ram.
// Clear, key and decrypt items that produce no letter leave in_ready high.
// Encrypt of a placed letter and a decoding token close go through the registered
// RAM read, the result register and then the output register, with input held off.
// Finish holds off input while the placer walks all 26 letters, one per cycle.
// Reset (rst, synchronous) empties the square and token; RAMs are not cleared.
module keyed_polybius_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [7:0] byte_in,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [2:0] row_digit,
  output logic [2:0] col_digit,
  output logic [6:0] letter_out
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_ENC  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [kpc_pkg::IDX_W-1:0] sweep_cnt;

  // Token being gathered from decrypt bytes.
  logic [1:0] token_length;
  logic [2:0] token_first;
  logic [2:0] token_second;
  logic       token_digits_ok;

  // Result waiting for the output register.
  logic       res_kind;
  logic [2:0] res_row;
  logic [2:0] res_col;
  logic [6:0] res_letter;

  logic                 accept;
  kpc_pkg::lidx_t       li;
  kpc_pkg::place_req_t  preq;
  kpc_pkg::place_stat_t pstat;
  logic                 pwe;

  logic [kpc_pkg::POS_W-1:0] pos_rdata;
  logic [kpc_pkg::IDX_W-1:0] sq_rdata;

  logic       sp;
  logic [2:0] dig;
  logic       close;
  logic [1:0] len_next;
  logic [2:0] first_next;
  logic [2:0] second_next;
  logic       ok_next;
  logic [1:0] cl_len;
  logic [2:0] cl_first;
  logic [2:0] cl_second;
  logic       cl_ok;
  logic [kpc_pkg::POS_W-1:0] code_cell;
  logic       close_hit;
  logic       enc_hit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign li       = kpc_pkg::letter_index(byte_in);

  // The placer serves both single key bytes and the finish sweep.
  always_comb begin
    preq.clear = accept && (op == kpc_pkg::OP_CLEAR);
    preq.place = (accept && (op == kpc_pkg::OP_KEY) && li.ok) || (state == S_FILL);
    preq.idx   = (state == S_FILL) ? sweep_cnt : li.idx;
  end

  kpc_placer u_placer (
    .clk  (clk),
    .rst  (rst),
    .req  (preq),
    .we   (pwe),
    .stat (pstat)
  );

  // Token update for a non-space byte, then the values a close would see:
  // a space closes what is already held, end of text closes after the byte.
  always_comb begin
    sp          = kpc_pkg::is_space(byte_in);
    dig         = kpc_pkg::digit_of(byte_in);
    ok_next     = token_digits_ok && (dig != 3'd0);
    first_next  = (token_length == 2'd0) ? dig : token_first;
    second_next = (token_length == 2'd1) ? dig : token_second;
    len_next    = (token_length == 2'd3) ? token_length : token_length + 2'd1;
    close       = sp || end_of_text;
    if (sp) begin
      cl_len    = token_length;
      cl_first  = token_first;
      cl_second = token_second;
      cl_ok     = token_digits_ok;
    end else begin
      cl_len    = len_next;
      cl_first  = first_next;
      cl_second = second_next;
      cl_ok     = ok_next;
    end
    code_cell = kpc_pkg::cell_of(cl_first, cl_second);
    close_hit = close && (cl_len == 2'd2) && cl_ok && (code_cell < pstat.fill);
    enc_hit   = li.ok && pstat.mask[li.idx];
  end

  // square_letters: cell -> letter index, written at the fill position.
  kpc_ram #(
    .WIDTH (kpc_pkg::IDX_W),
    .DEPTH (kpc_pkg::CELLS)
  ) u_square (
    .clk   (clk),
    .we    (pwe),
    .waddr (pstat.fill),
    .wdata (preq.idx),
    .raddr (code_cell),
    .rdata (sq_rdata)
  );

  // letter_position: letter index -> cell.
  kpc_ram #(
    .WIDTH (kpc_pkg::POS_W),
    .DEPTH (kpc_pkg::LETTERS)
  ) u_position (
    .clk   (clk),
    .we    (pwe),
    .waddr (preq.idx),
    .wdata (pstat.fill),
    .raddr (li.idx),
    .rdata (pos_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sweep_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (op == kpc_pkg::OP_FINISH) begin
              state     <= S_FILL;
              sweep_cnt <= '0;
            end else if (op == kpc_pkg::OP_ENC && enc_hit) begin
              state <= S_ENC;
            end else if (op == kpc_pkg::OP_DEC && close_hit) begin
              state <= S_DEC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FILL: begin
          // Advance through every letter; the placer drops J and repeats.
          sweep_cnt <= sweep_cnt + kpc_pkg::IDX_W'(1);
          if (sweep_cnt == kpc_pkg::IDX_W'(kpc_pkg::LETTERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_ENC, S_DEC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Token state: kept across clear key, reset on every close.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_length    <= 2'd0;
      token_first     <= 3'd0;
      token_second    <= 3'd0;
      token_digits_ok <= 1'b1;
    end else if (accept && op == kpc_pkg::OP_DEC) begin
      if (close) begin
        token_length    <= 2'd0;
        token_first     <= 3'd0;
        token_second    <= 3'd0;
        token_digits_ok <= 1'b1;
      end else begin
        token_length    <= len_next;
        token_first     <= first_next;
        token_second    <= second_next;
        token_digits_ok <= ok_next;
      end
    end
  end

  // Build the result from the RAM read data.
  always_ff @(posedge clk) begin
    if (state == S_ENC) begin
      res_kind   <= kpc_pkg::KIND_PAIR;
      res_row    <= kpc_pkg::pos_row(pos_rdata);
      res_col    <= kpc_pkg::pos_col(pos_rdata);
      res_letter <= 7'd0;
    end else if (state == S_DEC) begin
      res_kind   <= kpc_pkg::KIND_LETTER;
      res_row    <= 3'd0;
      res_col    <= 3'd0;
      res_letter <= 7'(sq_rdata) + 7'h41;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      kind       <= res_kind;
      row_digit  <= res_row;
      col_digit  <= res_col;
      letter_out <= res_letter;
    end
  end

endmodule

[hw/rtl/kpc_checker.sv]
// Port-level checker for keyed_polybius_cipher, attached by bind below.
// Depends on kpc_pkg and the top level's port list.
module kpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] op,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [2:0] row_digit,
  input logic [2:0] col_digit,
  input logic [6:0] letter_out
);

  // A coordinate pair carries digits 1..5 and no letter.
  a_pair_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == kpc_pkg::KIND_PAIR) |->
      (row_digit >= 3'd1 && row_digit <= 3'd5 && col_digit >= 3'd1 && col_digit <= 3'd5
       && letter_out == 7'd0))
    else $error("bad coordinate pair result");

  // A decrypted letter is A..Z with zero digits, never J.
  a_letter_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == kpc_pkg::KIND_LETTER) |->
      (row_digit == 3'd0 && col_digit == 3'd0 && letter_out >= 7'h41
       && letter_out <= 7'h5a && letter_out != 7'h4a))
    else $error("bad decrypted letter result");

  // The finish sweep blocks input on the next cycle.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == kpc_pkg::OP_FINISH) |=> !in_ready)
    else $error("input not held off during finish sweep");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kind) && $stable(row_digit) && $stable(col_digit)
       && $stable(letter_out)))
    else $error("stalled result changed");

endmodule

bind keyed_polybius_cipher kpc_checker u_kpc_checker (.*);
